@@ hdl/amo_pkg.sv @@
// Package for the arm motion odometer: field widths, command and register codes,
// sequencer state type. No dependencies.
`default_nettype none
package amo_pkg;

	localparam int JOINT_COUNT  = 6;
	localparam int JOINT_FIELDS = 6;
	localparam int TOOL_AXES    = 3;
	localparam int NAXES        = TOOL_AXES + JOINT_COUNT;

	localparam int POS_W   = 24;
	localparam int THR_W   = 20;
	localparam int ACC_W   = 48;
	localparam int SEG_W   = 16;
	localparam int SQ_W    = 50;
	localparam int ROOT_W  = SQ_W / 2;
	localparam int REM_W   = ROOT_W + 2;
	localparam int CFG_IDX_W = 2;

	localparam int SQ_STEPS = ROOT_W;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(100);
	localparam logic [ACC_W-1:0] ACC_MAX   = '1;

	typedef enum logic [1:0] {
		MODE_SAMPLE = 2'd0,
		MODE_START  = 2'd1,
		MODE_STOP   = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOOL_THR  = CFG_IDX_W'(0),
		REG_JOINT_THR = CFG_IDX_W'(1)
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SQRT,
		ST_ACC,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

@@ hdl/amo_cmd_if.sv @@
// Command and sample request channel of the arm motion odometer.
// Depends on amo_pkg.
`default_nettype none
interface amo_cmd_if;
	import amo_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [1:0]              mode;
	logic signed [POS_W-1:0] tool_x;
	logic signed [POS_W-1:0] tool_y;
	logic signed [POS_W-1:0] tool_z;
	logic signed [POS_W-1:0] joint_0;
	logic signed [POS_W-1:0] joint_1;
	logic signed [POS_W-1:0] joint_2;
	logic signed [POS_W-1:0] joint_3;
	logic signed [POS_W-1:0] joint_4;
	logic signed [POS_W-1:0] joint_5;

	modport source (output valid, mode, tool_x, tool_y, tool_z,
		joint_0, joint_1, joint_2, joint_3, joint_4, joint_5, input ready);
	modport sink (input valid, mode, tool_x, tool_y, tool_z,
		joint_0, joint_1, joint_2, joint_3, joint_4, joint_5, output ready);

endinterface
`default_nettype wire

@@ hdl/amo_res_if.sv @@
// Segment totals result channel of the arm motion odometer.
// Depends on amo_pkg.
`default_nettype none
interface amo_res_if;
	import amo_pkg::*;

	logic             valid;
	logic             ready;
	logic [SEG_W-1:0] segment_number;
	logic             had_data;
	logic [ACC_W-1:0] tool_path_total;
	logic [ACC_W-1:0] joint_total_0;
	logic [ACC_W-1:0] joint_total_1;
	logic [ACC_W-1:0] joint_total_2;
	logic [ACC_W-1:0] joint_total_3;
	logic [ACC_W-1:0] joint_total_4;
	logic [ACC_W-1:0] joint_total_5;

	modport source (output valid, segment_number, had_data, tool_path_total,
		joint_total_0, joint_total_1, joint_total_2, joint_total_3,
		joint_total_4, joint_total_5, input ready);
	modport sink (input valid, segment_number, had_data, tool_path_total,
		joint_total_0, joint_total_1, joint_total_2, joint_total_3,
		joint_total_4, joint_total_5, output ready);

endinterface
`default_nettype wire

@@ hdl/amo_cfg_if.sv @@
// Register write channel of the arm motion odometer.
// Depends on amo_pkg.
`default_nettype none
interface amo_cfg_if;
	import amo_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [THR_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);

endinterface
`default_nettype wire

@@ hdl/arm_motion_odometer_unit.sv @@
// Arm motion odometer: per-segment tool path and joint motion totals.
// Depends on amo_pkg, amo_cmd_if, amo_res_if and amo_cfg_if.
//
// Start commands, and stops that do not report, are handled in the idle state. A
// stop that reports passes an emit state to hand its totals to the output register,
// waiting there while that register is still full. A position sample that is
// compared with the reference walks the axes through one shared subtract/absolute
// unit, one 24 x 24 multiplier and a 25-step restoring square root; when it counts
// as movement, one saturating 48-bit adder then updates the accumulators in turn.
// The block takes no request meanwhile; register writes are accepted at any time.
`default_nettype none
module arm_motion_odometer_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	amo_cmd_if.sink   cmd,
	amo_res_if.source res,
	amo_cfg_if.sink   cfg
);
	import amo_pkg::*;

	localparam int AX_W  = (NAXES > 1) ? $clog2(NAXES) : 1;
	localparam int JW    = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
	localparam int AI_W  = $clog2(JOINT_COUNT + 1);
	localparam int CNT_W = $clog2(SQ_STEPS);

	state_t state_q, state_d;

	logic             recording_q, awaiting_q;
	logic [SEG_W-1:0] seg_q;
	logic [THR_W-1:0] tthr_q, jthr_q;

	logic signed [POS_W-1:0] smp_in [NAXES];
	logic signed [POS_W-1:0] jf_in  [JOINT_FIELDS];
	logic signed [POS_W-1:0] smp_q  [NAXES];
	logic signed [POS_W-1:0] ref_q  [NAXES];

	logic [AX_W-1:0]  idx_q;
	logic             issue_done_q;
	logic [POS_W-1:0] absd_s1;
	logic [AX_W-1:0]  ax_s1;
	logic             vld_s1;
	logic [2*POS_W-1:0] prod_s2;
	logic             vld_s2;
	logic [SQ_W-1:0]  sq_q, rad_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q, root_nx;
	logic [CNT_W-1:0] cnt_q;
	logic             moved_q, moved_now;
	logic [POS_W-1:0] jstep_q [JOINT_COUNT];
	logic [ACC_W-1:0] acc_q [JOINT_COUNT + 1];
	logic [AI_W-1:0]  aidx_q;

	logic             out_valid_q;
	logic [SEG_W-1:0] out_seg_q;
	logic             out_had_q;
	logic [ACC_W-1:0] out_tool_q;
	logic [ACC_W-1:0] out_jt_q [JOINT_FIELDS];

	logic             cmd_acc, load_out;
	logic signed [POS_W:0] diff;
	logic [POS_W:0]   diff_abs;
	logic [REM_W+1:0] sq_raw, sq_trial;
	logic             sq_ge;
	logic [ROOT_W-1:0] step_op;
	logic [ACC_W:0]   acc_sum;

	assign jf_in[0] = cmd.joint_0;
	assign jf_in[1] = cmd.joint_1;
	assign jf_in[2] = cmd.joint_2;
	assign jf_in[3] = cmd.joint_3;
	assign jf_in[4] = cmd.joint_4;
	assign jf_in[5] = cmd.joint_5;

	always_comb begin
		smp_in[0] = cmd.tool_x;
		smp_in[1] = cmd.tool_y;
		smp_in[2] = cmd.tool_z;
		for (int j = 0; j < JOINT_COUNT; j++) begin
			if (j < JOINT_FIELDS)
				smp_in[TOOL_AXES + j] = jf_in[j];
			else
				smp_in[TOOL_AXES + j] = '0;
		end
	end

	// shared subtract and absolute value
	always_comb begin
		diff = {smp_q[idx_q][POS_W-1], smp_q[idx_q]} - {ref_q[idx_q][POS_W-1], ref_q[idx_q]};
		diff_abs = diff[POS_W] ? (POS_W+1)'(-diff) : (POS_W+1)'(diff);
	end

	// one restoring square root step
	always_comb begin
		sq_raw   = {rem_q, rad_q[SQ_W-1 -: 2]};
		sq_trial = (REM_W+2)'({root_q, 2'b01});
		sq_ge    = sq_raw >= sq_trial;
		root_nx  = {root_q[ROOT_W-2:0], sq_ge};
		moved_now = moved_q || (root_nx > ROOT_W'(tthr_q));
	end

	// shared saturating adder
	always_comb begin
		if (aidx_q == '0)
			step_op = root_q;
		else
			step_op = ROOT_W'(jstep_q[JW'(aidx_q - AI_W'(1))]);
		acc_sum = {1'b0, acc_q[aidx_q]} + (ACC_W+1)'(step_op);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					unique case (mode_t'(cmd.mode))
						MODE_SAMPLE: if (recording_q && !awaiting_q) state_d = ST_DIFF;
						MODE_STOP:   if (recording_q) state_d = ST_EMIT;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_DIFF: if (issue_done_q && !vld_s1 && !vld_s2) state_d = ST_SQRT;
			ST_SQRT: if (cnt_q == CNT_W'(SQ_STEPS - 1)) state_d = moved_now ? ST_ACC : ST_IDLE;
			ST_ACC:  if (aidx_q == AI_W'(JOINT_COUNT)) state_d = ST_IDLE;
			ST_EMIT: if (!out_valid_q || res.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		cmd.ready = (state_q == ST_IDLE);
		cfg.ready = 1'b1;
		res.valid = out_valid_q;
		cmd_acc   = cmd.valid && (state_q == ST_IDLE);
		load_out  = (state_q == ST_EMIT) && (!out_valid_q || res.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tthr_q <= THR_RESET;
			jthr_q <= THR_RESET;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_TOOL_THR:  tthr_q <= cfg.data;
				REG_JOINT_THR: jthr_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// segment control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recording_q <= 1'b0;
			awaiting_q  <= 1'b1;
			seg_q       <= '0;
		end else if (cmd_acc) begin
			case (mode_t'(cmd.mode))
				MODE_START: begin
					seg_q       <= seg_q + SEG_W'(1);
					awaiting_q  <= 1'b1;
					recording_q <= 1'b1;
				end
				MODE_STOP: recording_q <= 1'b0;
				MODE_SAMPLE: if (recording_q) awaiting_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// sample and reference
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NAXES; i++) ref_q[i] <= '0;
		end else if (cmd_acc && mode_t'(cmd.mode) == MODE_SAMPLE && recording_q && awaiting_q) begin
			ref_q <= smp_in;
		end else if (state_q == ST_ACC && aidx_q == AI_W'(JOINT_COUNT)) begin
			ref_q <= smp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc)
			smp_q <= smp_in;
	end

	// axis walk: difference, square, sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			issue_done_q <= 1'b0;
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			moved_q      <= 1'b0;
		end else begin
			if (cmd_acc) begin
				idx_q        <= '0;
				issue_done_q <= 1'b0;
				moved_q      <= 1'b0;
			end else if (state_q == ST_DIFF && !issue_done_q) begin
				idx_q <= idx_q + AX_W'(1);
				if (idx_q == AX_W'(NAXES - 1)) issue_done_q <= 1'b1;
			end
			vld_s1 <= (state_q == ST_DIFF) && !issue_done_q;
			vld_s2 <= vld_s1 && (ax_s1 < AX_W'(TOOL_AXES));
			if (vld_s1 && ax_s1 >= AX_W'(TOOL_AXES) && ({1'b0, absd_s1} > (POS_W+1)'(jthr_q)))
				moved_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		absd_s1 <= diff_abs[POS_W-1:0];
		ax_s1   <= idx_q;
		prod_s2 <= absd_s1 * absd_s1;
		if (vld_s1 && ax_s1 >= AX_W'(TOOL_AXES))
			jstep_q[JW'(ax_s1 - AX_W'(TOOL_AXES))] <= absd_s1;
		if (cmd_acc)
			sq_q <= '0;
		else if (vld_s2)
			sq_q <= sq_q + SQ_W'(prod_s2);
	end

	// square root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_DIFF) begin
			cnt_q <= '0;
		end else if (state_q == ST_SQRT) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIFF) begin
			rad_q  <= sq_q;
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == ST_SQRT) begin
			rad_q  <= rad_q << 2;
			rem_q  <= sq_ge ? REM_W'(sq_raw - sq_trial) : REM_W'(sq_raw);
			root_q <= root_nx;
		end
	end

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aidx_q <= '0;
			for (int i = 0; i <= JOINT_COUNT; i++) acc_q[i] <= '0;
		end else begin
			if (cmd_acc && mode_t'(cmd.mode) == MODE_START) begin
				for (int i = 0; i <= JOINT_COUNT; i++) acc_q[i] <= '0;
			end else if (state_q == ST_ACC) begin
				acc_q[aidx_q] <= acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
			end
			if (state_q == ST_ACC)
				aidx_q <= aidx_q + AI_W'(1);
			else
				aidx_q <= '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_seg_q  <= seg_q;
			out_had_q  <= !awaiting_q;
			out_tool_q <= acc_q[0];
			for (int j = 0; j < JOINT_FIELDS; j++) begin
				if (j < JOINT_COUNT)
					out_jt_q[j] <= acc_q[j + 1];
				else
					out_jt_q[j] <= '0;
			end
		end
	end

	assign res.segment_number  = out_seg_q;
	assign res.had_data        = out_had_q;
	assign res.tool_path_total = out_tool_q;
	assign res.joint_total_0   = out_jt_q[0];
	assign res.joint_total_1   = out_jt_q[1];
	assign res.joint_total_2   = out_jt_q[2];
	assign res.joint_total_3   = out_jt_q[3];
	assign res.joint_total_4   = out_jt_q[4];
	assign res.joint_total_5   = out_jt_q[5];

`ifndef SYNTHESIS
	a_acc_from_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC && $past(state_q) != ST_ACC) |-> $past(state_q) == ST_SQRT)
		else $error("accumulate phase entered without square root");

	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACC |->
			((52'(root_q) * 52'(root_q)) <= 52'(sq_q)) &&
			((52'(root_q) + 52'd1) * (52'(root_q) + 52'd1) > 52'(sq_q)))
		else $error("tool step is not the floor square root");

	a_empty_segment: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.had_data) |-> (res.tool_path_total == '0 && res.joint_total_0 == '0))
		else $error("segment without data reports motion");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb_arm_motion_odometer_unit.sv @@
`timescale 1ns / 100ps
// Testbench for arm_motion_odometer_unit: a stimulus table, then randomised segments
// under several threshold settings, checked against an in-bench odometer predictor.
// Depends on amo_pkg, amo_cmd_if, amo_res_if, amo_cfg_if and the unit itself.
module tb_arm_motion_odometer_unit;
	import amo_pkg::*;

	localparam logic [1:0] MODE_RSVD = 2'd3;
	localparam int POS_MIN = -(1 << (POS_W - 1));
	localparam int POS_MAX = (1 << (POS_W - 1)) - 1;
	localparam logic [THR_W-1:0] THR_MAX = '1;
	localparam int SETTLE_CYCLES = 64;
	localparam int LONG_HOLD = 3000;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int MAX_PRINTED = 50;

	typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_TOTALS} exp_kind_t;
	typedef logic [NAXES-1:0][POS_W-1:0] pos_t;

	typedef struct packed {
		logic [SEG_W-1:0]                  seg;
		logic                              had;
		logic [ACC_W-1:0]                  tool;
		logic [JOINT_COUNT-1:0][ACC_W-1:0] joint;
	} seg_totals_t;

	typedef struct packed {
		logic [1:0]  mode;
		pos_t        pos;
		exp_kind_t   kind;
		seg_totals_t want;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n;

	amo_cmd_if cmd_ch ();
	amo_res_if res_ch ();
	amo_cfg_if cfg_ch ();

	arm_motion_odometer_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// odometer predictor state
	bit                      recording_m;
	logic [SEG_W-1:0]        seg_count;
	bit                      awaiting_anchor;
	logic signed [POS_W-1:0] anchor_pos [NAXES];
	logic [ACC_W-1:0]        tool_sum;
	logic [ACC_W-1:0]        joint_sum [JOINT_COUNT];
	logic [THR_W-1:0]        tool_thr;
	logic [THR_W-1:0]        joint_thr;

	cmd_row_t    directed_rows [$];
	seg_totals_t pending_totals [$];
	pos_t        walk;
	bit          src_idling;
	bit          sink_idling;
	bit          hold_request;
	int          hold_left;
	int          idle_left;
	int          mismatch_count;
	int          cycle_count;

	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = ROOT_W; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	function automatic logic [ACC_W-1:0] sum_sat(input logic [ACC_W-1:0] a,
		input longint unsigned b);
		longint unsigned s;
		s = 64'(a) + b;
		return (s > 64'(ACC_MAX)) ? ACC_MAX : s[ACC_W-1:0];
	endfunction

	function automatic bit odometer_predict(input logic [1:0] mode, input pos_t pos,
		output seg_totals_t t);
		longint unsigned step [NAXES];
		longint unsigned sq;
		longint unsigned tool_step;
		longint d;
		bit moved;
		t = '0;
		case (mode)
			MODE_START: begin
				seg_count = seg_count + 1'b1;
				tool_sum = '0;
				for (int j = 0; j < JOINT_COUNT; j++)
					joint_sum[j] = '0;
				awaiting_anchor = 1'b1;
				recording_m = 1'b1;
				return 1'b0;
			end
			MODE_STOP: begin
				if (!recording_m)
					return 1'b0;
				recording_m = 1'b0;
				t.seg = seg_count;
				t.had = !awaiting_anchor;
				t.tool = tool_sum;
				for (int j = 0; j < JOINT_COUNT; j++)
					t.joint[j] = joint_sum[j];
				return 1'b1;
			end
			MODE_SAMPLE: begin
				if (!recording_m)
					return 1'b0;
				if (awaiting_anchor) begin
					for (int i = 0; i < NAXES; i++)
						anchor_pos[i] = pos[i];
					awaiting_anchor = 1'b0;
					return 1'b0;
				end
				for (int i = 0; i < NAXES; i++) begin
					d = longint'($signed(pos[i])) - longint'(anchor_pos[i]);
					step[i] = (d < 0) ? -d : d;
				end
				sq = 0;
				for (int i = 0; i < TOOL_AXES; i++)
					sq += step[i] * step[i];
				tool_step = floor_root(sq);
				moved = tool_step > tool_thr;
				for (int j = 0; j < JOINT_COUNT; j++)
					if (step[TOOL_AXES + j] > joint_thr)
						moved = 1'b1;
				if (!moved)
					return 1'b0;
				tool_sum = sum_sat(tool_sum, tool_step);
				for (int j = 0; j < JOINT_COUNT; j++)
					joint_sum[j] = sum_sat(joint_sum[j], step[TOOL_AXES + j]);
				for (int i = 0; i < NAXES; i++)
					anchor_pos[i] = pos[i];
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 16);
		return $urandom_range(40, 150);
	endfunction

	function automatic pos_t pos9(input int a0, a1, a2, a3, a4, a5, a6, a7, a8);
		int vals [NAXES] = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
		pos_t p;
		for (int i = 0; i < NAXES; i++)
			p[i] = POS_W'(vals[i]);
		return p;
	endfunction

	function automatic pos_t all_pos(input int v);
		return pos9(v, v, v, v, v, v, v, v, v);
	endfunction

	function automatic pos_t random_pos();
		pos_t p;
		for (int i = 0; i < NAXES; i++)
			p[i] = POS_W'($urandom);
		return p;
	endfunction

	// advance the walk: moves from near the thresholds up to large steps, now and then a jump
	function automatic pos_t next_walk(input pos_t p);
		int unsigned scale;
		int unsigned delta;
		bit jump;
		jump = 1'b0;
		case ($urandom_range(0, 5))
			0: scale = 16;
			1: scale = 128;
			2: scale = 512;
			3: scale = 1 << 20;
			4: scale = 1 << 22;
			default: jump = 1'b1;
		endcase
		for (int i = 0; i < NAXES; i++) begin
			if ($urandom_range(0, 2) != 0) begin
				if (jump) begin
					p[i] = POS_W'($urandom);
				end else begin
					delta = $urandom_range(0, scale);
					if ($urandom_range(0, 1) != 0)
						p[i] = p[i] - POS_W'(delta);
					else
						p[i] = p[i] + POS_W'(delta);
				end
			end
		end
		return p;
	endfunction

	function automatic seg_totals_t seg_sum(input int seg, input bit had, input int tool,
		input int j0);
		seg_totals_t t;
		t = '0;
		t.seg = SEG_W'(seg);
		t.had = had;
		t.tool = ACC_W'(tool);
		t.joint[0] = ACC_W'(j0);
		return t;
	endfunction

	task automatic add_row(input logic [1:0] mode, input pos_t pos,
		input exp_kind_t kind = EXP_MODEL, input seg_totals_t want = '0);
		cmd_row_t row;
		row.mode = mode;
		row.pos = pos;
		row.kind = kind;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("%0t mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [ACC_W-1:0] got,
		input logic [ACC_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
	endtask

	// entered and left at a falling edge
	task automatic send_req(input logic [1:0] mode, input pos_t pos,
		input exp_kind_t kind = EXP_MODEL, input seg_totals_t want = '0);
		int gap;
		bit has_totals;
		seg_totals_t predicted;
		gap = src_idling ? gap_len() : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode <= mode;
		cmd_ch.tool_x <= pos[0];
		cmd_ch.tool_y <= pos[1];
		cmd_ch.tool_z <= pos[2];
		cmd_ch.joint_0 <= pos[3];
		cmd_ch.joint_1 <= pos[4];
		cmd_ch.joint_2 <= pos[5];
		cmd_ch.joint_3 <= pos[6];
		cmd_ch.joint_4 <= pos[7];
		cmd_ch.joint_5 <= pos[8];
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		has_totals = odometer_predict(mode, pos, predicted);
		case (kind)
			EXP_MODEL: if (has_totals) pending_totals.push_back(predicted);
			EXP_TOTALS: pending_totals.push_back(want);
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic drain_totals();
		cmd_ch.valid <= 1'b0;
		while (pending_totals.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [THR_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		if (idx == REG_TOOL_THR)
			tool_thr = value;
		else
			joint_thr = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_noise();
		case ($urandom_range(0, 2))
			0: send_req(MODE_RSVD, random_pos());
			1: send_req(MODE_STOP, random_pos());
			default: send_req(MODE_SAMPLE, random_pos());
		endcase
	endtask

	// mostly whole segments with random content; some left open, some noise
	task automatic run_phase(input int n_items);
		int sent;
		int samples;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 85) begin
				send_req(MODE_START, random_pos());
				sent++;
				if ($urandom_range(0, 3) == 0)
					walk = random_pos();
				samples = $urandom_range(0, 10);
				repeat (samples) begin
					if ($urandom_range(0, 19) == 0)
						send_noise();
					walk = next_walk(walk);
					send_req(MODE_SAMPLE, walk);
					sent++;
				end
				if ($urandom_range(0, 9) != 0) begin
					send_req(MODE_STOP, random_pos());
					sent++;
				end
				if ($urandom_range(0, 15) == 0)
					drain_totals();
			end else begin
				send_noise();
			end
		end
	endtask

	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = LONG_HOLD;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else if (idle_left > 0) begin
			idle_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
			idle_left = sink_idling ? gap_len() : 0;
		end
	end

	always @(posedge clk) begin
		seg_totals_t want;
		logic [JOINT_COUNT-1:0][ACC_W-1:0] seen_joints;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_totals.size() == 0) begin
				report_mismatch($sformatf("totals of segment %0d with none pending",
					res_ch.segment_number));
			end else begin
				want = pending_totals.pop_front();
				seen_joints = {res_ch.joint_total_5, res_ch.joint_total_4,
					res_ch.joint_total_3, res_ch.joint_total_2,
					res_ch.joint_total_1, res_ch.joint_total_0};
				check_field("segment_number", ACC_W'(res_ch.segment_number),
					ACC_W'(want.seg));
				check_field("had_data", ACC_W'(res_ch.had_data), ACC_W'(want.had));
				check_field("tool_path_total", res_ch.tool_path_total, want.tool);
				for (int j = 0; j < JOINT_COUNT; j++)
					check_field($sformatf("joint_total_%0d", j), seen_joints[j],
						want.joint[j]);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = MODE_SAMPLE;
		cmd_ch.tool_x = '0;
		cmd_ch.tool_y = '0;
		cmd_ch.tool_z = '0;
		cmd_ch.joint_0 = '0;
		cmd_ch.joint_1 = '0;
		cmd_ch.joint_2 = '0;
		cmd_ch.joint_3 = '0;
		cmd_ch.joint_4 = '0;
		cmd_ch.joint_5 = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_TOOL_THR;
		cfg_ch.data = '0;
		hold_request = 1'b0;
		hold_left = 0;
		idle_left = 0;
		mismatch_count = 0;
		cycle_count = 0;
		src_idling = 1'b1;
		sink_idling = 1'b1;
		walk = '0;
		recording_m = 1'b0;
		seg_count = '0;
		awaiting_anchor = 1'b1;
		tool_sum = '0;
		for (int i = 0; i < NAXES; i++)
			anchor_pos[i] = '0;
		for (int j = 0; j < JOINT_COUNT; j++)
			joint_sum[j] = '0;
		tool_thr = THR_RESET;
		joint_thr = THR_RESET;

		add_row(MODE_STOP, all_pos(0), EXP_NONE);
		add_row(MODE_SAMPLE, all_pos(POS_MAX), EXP_NONE);
		add_row(MODE_RSVD, all_pos(POS_MIN), EXP_NONE);
		add_row(MODE_START, all_pos(POS_MIN), EXP_NONE);
		add_row(MODE_STOP, all_pos(POS_MAX), EXP_TOTALS, seg_sum(1, 1'b0, 0, 0));
		add_row(MODE_START, all_pos(0), EXP_NONE);
		add_row(MODE_SAMPLE, pos9(1000, -2000, 3000, 10, -20, 30, -40, 50, -60));
		add_row(MODE_STOP, all_pos(0), EXP_TOTALS, seg_sum(2, 1'b1, 0, 0));
		add_row(MODE_START, all_pos(0), EXP_NONE);
		add_row(MODE_SAMPLE, all_pos(0));
		add_row(MODE_SAMPLE, pos9(5000, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(MODE_START, all_pos(0), EXP_NONE);
		add_row(MODE_STOP, all_pos(0), EXP_TOTALS, seg_sum(4, 1'b0, 0, 0));
		add_row(MODE_START, all_pos(0));
		add_row(MODE_SAMPLE, all_pos(POS_MIN));
		add_row(MODE_SAMPLE, all_pos(POS_MAX));
		add_row(MODE_RSVD, pos9(7, -7, 7, 900, -900, 900, -900, 900, -900), EXP_NONE);
		add_row(MODE_SAMPLE, all_pos(POS_MIN));
		add_row(MODE_STOP, all_pos(0));
		add_row(MODE_START, all_pos(0));
		add_row(MODE_SAMPLE, all_pos(0));
		add_row(MODE_SAMPLE, pos9(100, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(MODE_SAMPLE, pos9(101, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(MODE_SAMPLE, pos9(101, 0, 0, 101, 0, 0, 0, 0, 0));
		add_row(MODE_SAMPLE, pos9(101, 0, 0, 201, 0, 0, 0, 0, 0));
		add_row(MODE_STOP, all_pos(0), EXP_TOTALS, seg_sum(6, 1'b1, 101, 101));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k])
			send_req(directed_rows[k].mode, directed_rows[k].pos, directed_rows[k].kind,
				directed_rows[k].want);
		drain_totals();
		run_phase(150);

		drain_totals();
		cfg_write(REG_TOOL_THR, '0);
		cfg_write(REG_JOINT_THR, '0);
		src_idling = 1'b0;
		sink_idling = 1'b0;
		run_phase(120);

		// hold off the result side while requests keep coming
		drain_totals();
		cfg_write(REG_TOOL_THR, THR_MAX);
		cfg_write(REG_JOINT_THR, THR_MAX);
		src_idling = 1'b1;
		sink_idling = 1'b1;
		@(posedge clk);
		hold_request = 1'b1;
		@(negedge clk);
		run_phase(120);

		drain_totals();
		cfg_write(REG_TOOL_THR, THR_W'($urandom_range(0, (1 << THR_W) - 1)));
		cfg_write(REG_JOINT_THR, THR_W'($urandom_range(0, 4096)));
		src_idling = 1'b1;
		sink_idling = 1'b1;
		run_phase(150);

		drain_totals();
		cfg_write(REG_TOOL_THR, '0);
		cfg_write(REG_JOINT_THR, THR_MAX);
		run_phase(80);

		drain_totals();
		cfg_write(REG_TOOL_THR, THR_MAX);
		cfg_write(REG_JOINT_THR, '0);
		run_phase(80);

		drain_totals();
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
